@@ rtl/tcse_pkg.sv @@
package tcse_pkg;

    // Command codes carried on the slave tuser.
    localparam logic [2:0] OP_RECEIVE = 3'd0;
    localparam logic [2:0] OP_LISTEN  = 3'd1;
    localparam logic [2:0] OP_CONNECT = 3'd2;
    localparam logic [2:0] OP_SEND    = 3'd3;
    localparam logic [2:0] OP_CLOSE   = 3'd4;

    // Connection states.
    localparam logic [3:0] CS_CLOSED     = 4'd0;
    localparam logic [3:0] CS_LISTEN     = 4'd1;
    localparam logic [3:0] CS_SYN_RCVD   = 4'd2;
    localparam logic [3:0] CS_SYN_SENT   = 4'd3;
    localparam logic [3:0] CS_ESTAB      = 4'd4;
    localparam logic [3:0] CS_FW1        = 4'd5;
    localparam logic [3:0] CS_FW2        = 4'd6;
    localparam logic [3:0] CS_PEER_FIN   = 4'd7;
    localparam logic [3:0] CS_LAST_ACK   = 4'd9;
    localparam logic [3:0] CS_LINGER     = 4'd10;

    // Segment flag bits.
    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_PSH = 8'h08;
    localparam logic [7:0] FL_ACK = 8'h10;

    // Result kinds.
    localparam logic [1:0] KD_STATUS  = 2'd0;
    localparam logic [1:0] KD_XMIT    = 2'd1;
    localparam logic [1:0] KD_DELIVER = 2'd2;

    // Status codes.
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_SHORT     = 3'd1;
    localparam logic [2:0] STS_NO_LISTEN = 3'd2;
    localparam logic [2:0] STS_FULL      = 3'd3;
    localparam logic [2:0] STS_NO_CONN   = 3'd4;
    localparam logic [2:0] STS_NOT_ESTAB = 3'd5;

    localparam logic [31:0] CLIENT_ISN  = 32'h0000_1000;
    localparam logic [31:0] SERVER_ISN  = 32'h0000_2000;
    localparam logic [15:0] MIN_SEGMENT = 16'd20;

    // Work selected for the execute step.
    localparam logic [2:0] MD_STATUS  = 3'd0;
    localparam logic [2:0] MD_RX_OLD  = 3'd1;
    localparam logic [2:0] MD_RX_NEW  = 3'd2;
    localparam logic [2:0] MD_LISTEN  = 3'd3;
    localparam logic [2:0] MD_CONNECT = 3'd4;
    localparam logic [2:0] MD_SEND    = 3'd5;
    localparam logic [2:0] MD_CLOSE   = 3'd6;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] ip;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [31:0] sseq;
        logic [31:0] rack;
    } t_entry;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [31:0] seq;
        logic [31:0] seq1;
        logic [7:0]  flags;
        logic [15:0] plen;
        logic [15:0] len;
    } t_rx;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] dlen;
    } t_rec;

    typedef struct packed {
        t_entry          entry;
        t_rec [2:0]      recs;
        logic [1:0]      nres;
        logic            release_slot;
    } t_plan;

    function automatic t_rec mk_rec(logic [1:0] kind, logic [2:0] status,
                                    logic [31:0] seq, logic [31:0] ack,
                                    logic [7:0] flags, logic [15:0] dlen);
        t_rec r;
        r.kind   = kind;
        r.status = status;
        r.seq    = seq;
        r.ack    = ack;
        r.flags  = flags;
        r.dlen   = dlen;
        return r;
    endfunction

endpackage

@@ rtl/tcse_plan.sv @@
module tcse_plan import tcse_pkg::*; (
    input  logic [2:0] i_mode,
    input  logic [2:0] i_stat,
    input  t_entry     i_cur,
    input  t_rx        i_rx,
    output t_plan      o_plan
);

    t_entry     e;
    t_rec [2:0] recs;
    logic [1:0] n;
    logic       rel;
    logic       fin;
    logic       syn;
    logic       ack;

    // Work out the new entry and the list of results for one command.
    always_comb begin
        e    = i_cur;
        recs = '0;
        n    = 2'd0;
        rel  = 1'b0;
        fin  = (i_rx.flags & FL_FIN) != 8'd0;
        syn  = (i_rx.flags & FL_SYN) != 8'd0;
        ack  = (i_rx.flags & FL_ACK) != 8'd0;
        unique case (i_mode)
            MD_RX_NEW: begin
                e         = '0;
                e.ip      = i_rx.ip;
                e.rport   = i_rx.rport;
                e.lport   = i_rx.lport;
                e.rack    = i_rx.seq1;
                e.state   = CS_SYN_RCVD;
                e.sseq    = SERVER_ISN + 32'd1;
                recs[n]   = mk_rec(KD_XMIT, STS_OK, SERVER_ISN, i_rx.seq1,
                                   FL_SYN | FL_ACK, 16'd0);
                n         = n + 2'd1;
            end
            MD_LISTEN: begin
                e       = '0;
                e.state = CS_LISTEN;
                e.lport = i_rx.lport;
                recs[n] = mk_rec(KD_STATUS, STS_OK, '0, '0, '0, '0);
                n       = n + 2'd1;
            end
            MD_CONNECT: begin
                e       = '0;
                e.ip    = i_rx.ip;
                e.rport = i_rx.rport;
                e.lport = i_rx.lport;
                e.state = CS_SYN_SENT;
                e.sseq  = CLIENT_ISN + 32'd1;
                recs[n] = mk_rec(KD_XMIT, STS_OK, CLIENT_ISN, '0, FL_SYN, 16'd0);
                n       = n + 2'd1;
            end
            MD_SEND: begin
                if (i_cur.state != CS_ESTAB) begin
                    recs[n] = mk_rec(KD_STATUS, STS_NOT_ESTAB, '0, '0, '0, '0);
                end else begin
                    recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_cur.rack,
                                     FL_ACK | FL_PSH, i_rx.len);
                    e.sseq  = i_cur.sseq + {16'd0, i_rx.len};
                end
                n = n + 2'd1;
            end
            MD_CLOSE: begin
                if (i_cur.state == CS_ESTAB || i_cur.state == CS_PEER_FIN) begin
                    recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_cur.rack,
                                     FL_FIN | FL_ACK, 16'd0);
                    n       = n + 2'd1;
                    e.sseq  = i_cur.sseq + 32'd1;
                    e.state = (i_cur.state == CS_ESTAB) ? CS_FW1 : CS_LAST_ACK;
                end
            end
            MD_RX_OLD: begin
                unique case (i_cur.state)
                    CS_SYN_SENT: begin
                        if (syn && ack) begin
                            e.rack  = i_rx.seq1;
                            e.state = CS_ESTAB;
                            recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_rx.seq1,
                                             FL_ACK, 16'd0);
                            n       = n + 2'd1;
                        end
                    end
                    CS_SYN_RCVD: begin
                        if (ack) e.state = CS_ESTAB;
                    end
                    CS_ESTAB: begin
                        if (i_rx.plen != 16'd0) begin
                            e.rack  = i_rx.seq + {16'd0, i_rx.plen};
                            recs[n] = mk_rec(KD_DELIVER, STS_OK, '0, '0, '0, i_rx.plen);
                            n       = n + 2'd1;
                        end
                        // A FIN here is acknowledged and our side closes at once,
                        // passing straight through the passive-close wait state.
                        if (fin) begin
                            e.rack  = i_rx.seq1;
                            recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_rx.seq1,
                                             FL_ACK, 16'd0);
                            n       = n + 2'd1;
                            recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_rx.seq1,
                                             FL_FIN | FL_ACK, 16'd0);
                            n       = n + 2'd1;
                            e.sseq  = i_cur.sseq + 32'd1;
                            e.state = CS_LAST_ACK;
                        end
                    end
                    CS_FW1, CS_FW2: begin
                        if (i_cur.state == CS_FW1 && ack) e.state = CS_FW2;
                        if (fin) begin
                            e.rack  = i_rx.seq1;
                            recs[n] = mk_rec(KD_XMIT, STS_OK, i_cur.sseq, i_rx.seq1,
                                             FL_ACK, 16'd0);
                            n       = n + 2'd1;
                            e.state = CS_LINGER;
                            rel     = 1'b1;
                        end
                    end
                    CS_LAST_ACK: begin
                        if (ack) begin
                            e.state = CS_CLOSED;
                            rel     = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                recs[n] = mk_rec(KD_STATUS, i_stat, '0, '0, '0, '0);
                n       = n + 2'd1;
            end
        endcase
        // Commands that produced nothing still report a status.
        if (n == 2'd0) begin
            recs[0] = mk_rec(KD_STATUS, STS_OK, '0, '0, '0, '0);
            n       = 2'd1;
        end
        o_plan.entry        = e;
        o_plan.recs         = recs;
        o_plan.nres         = n;
        o_plan.release_slot = rel;
    end

endmodule

@@ rtl/tcp_connection_state_engine_unit.sv @@
// A request is taken only in the idle state; the unit then scans the table,
// decides, executes and emits one result per cycle while the master side is
// ready (1 to 3 results). No new request is taken before the last result is
// emitted. The scan reads one entry per cycle via the table's single read port.
// Reset (i_rst_n low, synchronous) marks every entry free and empties the output.
module tcp_connection_state_engine_unit import tcse_pkg::*; #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // peer address, peer port, own port, seg_seq, seg_flags, header_words,
    // length, slot, then one zero bit
    input  logic [127:0] s_axis_tdata,
    // opcode
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, conn_slot, peer_ip, peer_port, own_port, tx_seq, tx_ack, tx_flags,
    // data_len, conn_state, then six zero bits
    output logic [167:0] m_axis_tdata,
    // kind
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW:0]   N_ENT   = (IW+1)'(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IX = IW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_EXEC   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]   r_fsm, n_fsm;
    logic [IW:0]  r_idx;
    logic         r_cmp_vld;
    logic [IW-1:0] r_cmp_ix;
    logic [TABLE_ENTRIES-1:0] r_active;

    // Latched request.
    logic [2:0]  r_op;
    t_rx         r_rx;
    logic [2:0]  r_slot;

    // Scan results.
    logic          r_mfound, r_lfound, r_ffound;
    logic [IW-1:0] r_mix, r_fix;

    // Decision.
    logic [2:0]    r_mode, n_mode;
    logic [2:0]    r_stat, n_stat;
    logic          r_hasc, n_hasc;
    logic [IW-1:0] r_c, n_c;

    // Table memory with registered read.
    t_entry        m_tab [TABLE_ENTRIES];
    t_entry        r_rd;
    logic [IW-1:0] rd_addr;

    t_plan  w_plan;
    t_entry w_cur;
    logic   w_alloc;
    t_plan  r_plan;
    logic [1:0] r_k;

    logic         r_ovalid;
    logic [167:0] r_odata;
    logic [1:0]   r_ouser;
    logic         r_olast;

    logic          acc;
    logic          w_fin_seg;
    logic [5:0]    w_hdr;
    logic [IW-1:0] w_sl_ix;
    t_rec          w_rec;
    logic          emit_go;

    assign acc       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_fsm == S_IDLE);
    assign w_hdr     = {s_axis_tdata[107:104], 2'b00};
    assign w_sl_ix   = IW'(r_slot);
    assign w_fin_seg = (r_mode == MD_RX_NEW) || (r_mode == MD_LISTEN) ||
                       (r_mode == MD_CONNECT);
    assign w_alloc   = w_fin_seg;
    assign w_cur     = w_alloc ? t_entry'('0) : r_rd;
    assign emit_go   = (r_fsm == S_EMIT) && (!r_ovalid || m_axis_tready);
    assign w_rec     = r_plan.recs[r_k];

    // Read address: the scan pointer, then the chosen connection.
    always_comb begin
        rd_addr = (r_fsm == S_SCAN) ? r_idx[IW-1:0] : n_c;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= m_tab[rd_addr];
        if (r_fsm == S_EXEC && r_hasc) begin
            m_tab[r_c] <= w_plan.entry;
        end
    end

    // Choose what the execute step does.
    always_comb begin
        n_mode = MD_STATUS;
        n_stat = STS_OK;
        n_hasc = 1'b0;
        n_c    = r_c;
        priority if (r_op == OP_RECEIVE) begin
            priority if (r_rx.len < MIN_SEGMENT) begin
                n_stat = STS_SHORT;
            end else if (r_mfound) begin
                n_mode = MD_RX_OLD;
                n_hasc = 1'b1;
                n_c    = r_mix;
            end else if ((r_rx.flags & FL_SYN) != 8'd0 && (r_rx.flags & FL_ACK) == 8'd0) begin
                priority if (!r_lfound) begin
                    n_stat = STS_NO_LISTEN;
                end else if (!r_ffound) begin
                    n_stat = STS_FULL;
                end else begin
                    n_mode = MD_RX_NEW;
                    n_hasc = 1'b1;
                    n_c    = r_fix;
                end
            end else begin
                n_stat = STS_NO_CONN;
            end
        end else if (r_op == OP_LISTEN || r_op == OP_CONNECT) begin
            if (r_ffound) begin
                n_mode = (r_op == OP_LISTEN) ? MD_LISTEN : MD_CONNECT;
                n_hasc = 1'b1;
                n_c    = r_fix;
            end else begin
                n_stat = STS_FULL;
            end
        end else if (r_op == OP_SEND || r_op == OP_CLOSE) begin
            if ((32'(r_slot) < TABLE_ENTRIES) && r_active[w_sl_ix]) begin
                n_mode = (r_op == OP_SEND) ? MD_SEND : MD_CLOSE;
                n_hasc = 1'b1;
                n_c    = w_sl_ix;
            end else begin
                n_stat = STS_NO_CONN;
            end
        end else begin
            n_stat = STS_OK;
        end
    end

    tcse_plan u_plan (
        .i_mode (r_mode),
        .i_stat (r_stat),
        .i_cur  (w_cur),
        .i_rx   (r_rx),
        .o_plan (w_plan)
    );

    // Sequencer next state.
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            S_IDLE:   if (acc) n_fsm = S_SCAN;
            S_SCAN:   if (r_cmp_vld && r_cmp_ix == LAST_IX) n_fsm = S_DECIDE;
            S_DECIDE: n_fsm = S_EXEC;
            S_EXEC:   n_fsm = S_EMIT;
            S_EMIT:   if (emit_go && (r_k == r_plan.nres - 2'd1)) n_fsm = S_IDLE;
            default:  n_fsm = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= S_IDLE;
            r_active  <= '0;
            r_ovalid  <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_idx     <= '0;
            r_k       <= '0;
        end else begin
            r_fsm     <= n_fsm;
            r_cmp_vld <= (r_fsm == S_SCAN) && (r_idx < N_ENT);
            if (acc) begin
                r_idx <= '0;
            end else if (r_fsm == S_SCAN && r_idx < N_ENT) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_fsm == S_EXEC) begin
                r_k <= '0;
                if (w_alloc) r_active[r_c] <= 1'b1;
                if (r_hasc && w_plan.release_slot) r_active[r_c] <= 1'b0;
            end else if (emit_go) begin
                r_k <= r_k + 2'd1;
            end
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request, scan, decision and plan registers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op       <= s_axis_tuser;
            r_rx.ip    <= s_axis_tdata[31:0];
            r_rx.rport <= s_axis_tdata[47:32];
            r_rx.lport <= s_axis_tdata[63:48];
            r_rx.seq   <= s_axis_tdata[95:64];
            r_rx.seq1  <= s_axis_tdata[95:64] + 32'd1;
            r_rx.flags <= s_axis_tdata[103:96];
            r_rx.len   <= s_axis_tdata[123:108];
            r_rx.plen  <= (s_axis_tdata[123:108] > {10'd0, w_hdr}) ?
                          s_axis_tdata[123:108] - {10'd0, w_hdr} : 16'd0;
            r_slot     <= s_axis_tdata[126:124];
            r_mfound   <= 1'b0;
            r_lfound   <= 1'b0;
            r_ffound   <= 1'b0;
        end else if (r_cmp_vld) begin
            if (r_active[r_cmp_ix] && !r_mfound && r_rd.ip == r_rx.ip &&
                r_rd.rport == r_rx.rport && r_rd.lport == r_rx.lport) begin
                r_mfound <= 1'b1;
                r_mix    <= r_cmp_ix;
            end
            if (r_active[r_cmp_ix] && r_rd.state == CS_LISTEN &&
                r_rd.lport == r_rx.lport) begin
                r_lfound <= 1'b1;
            end
            if (!r_active[r_cmp_ix] && !r_ffound) begin
                r_ffound <= 1'b1;
                r_fix    <= r_cmp_ix;
            end
        end
        r_cmp_ix <= r_idx[IW-1:0];
        if (r_fsm == S_DECIDE) begin
            r_mode <= n_mode;
            r_stat <= n_stat;
            r_hasc <= n_hasc;
            r_c    <= n_c;
        end
        if (r_fsm == S_EXEC) begin
            r_plan <= w_plan;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_ouser <= w_rec.kind;
            r_olast <= (r_k == r_plan.nres - 2'd1);
            r_odata <= {6'd0,
                        r_hasc ? r_plan.entry.state : 4'd0,
                        w_rec.dlen, w_rec.flags, w_rec.ack, w_rec.seq,
                        r_hasc ? r_plan.entry.lport : 16'd0,
                        r_hasc ? r_plan.entry.rport : 16'd0,
                        r_hasc ? r_plan.entry.ip : 32'd0,
                        r_hasc ? 3'(r_c) : 3'd0,
                        w_rec.status};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;
    assign m_axis_tlast  = r_olast;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !s_axis_tready)
        else $error("request taken while a command is in progress");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_EMIT) |-> (r_plan.nres != 2'd0 && r_k < r_plan.nres))
        else $error("result index beyond the planned count");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined result kind");

endmodule

@@ tb/tb_tcp_connection_state_engine_unit.sv @@
`timescale 1ns / 1ps

module tb_tcp_connection_state_engine_unit;
    import tcse_pkg::*;

    localparam int ENTRIES    = 8;
    localparam int IDLE_LIMIT = 3000;
    localparam int RAND_ITEMS = 440;
    localparam int LONG_HOLD  = 300;

    // One command as it travels on the slave side.
    typedef struct {
        logic [2:0]  op;
        logic [31:0] ip;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [31:0] seq;
        logic [7:0]  flags;
        logic [3:0]  hwords;
        logic [15:0] len;
        logic [2:0]  slot;
    } cmd_t;

    // One result as it leaves on the master side.
    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [2:0]  slot;
        logic [31:0] ip;
        logic [15:0] rport;
        logic [15:0] lport;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] dlen;
        logic [3:0]  state;
        logic        fin_mark;
    } res_t;

    // Directed stimulus row; typed status is checked where set.
    typedef struct {
        cmd_t       cmd;
        bit         chk;
        logic [2:0] sts;
    } row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [2:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    tcp_connection_state_engine_unit #(.TABLE_ENTRIES(ENTRIES)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Connection table mirror.
    bit          conn_act   [ENTRIES];
    logic [3:0]  conn_st    [ENTRIES];
    logic [31:0] conn_ip    [ENTRIES];
    logic [15:0] conn_rport [ENTRIES];
    logic [15:0] conn_lport [ENTRIES];
    logic [31:0] conn_sseq  [ENTRIES];
    logic [31:0] conn_rack  [ENTRIES];

    res_t step_res[$];
    res_t owed_q[$];

    int         errors = 0;
    int         idle_cycles = 0;
    bit         typed_chk = 0;
    logic [2:0] typed_sts = STS_OK;
    bit         hold_req = 0;
    int         burst_left = 0;

    always #10 i_clk = ~i_clk;

    // Result builders.
    function automatic void add_res(logic [1:0] kind, logic [2:0] status, int c,
                                    logic [31:0] seq, logic [31:0] ack,
                                    logic [7:0] flags, logic [15:0] dlen);
        res_t r;
        if (step_res.size() >= 3) return;
        r = '{default: '0};
        r.kind = kind;
        r.status = status;
        if (c >= 0) begin
            r.slot = c[2:0];
            r.ip = conn_ip[c];
            r.rport = conn_rport[c];
            r.lport = conn_lport[c];
        end
        r.seq = seq;
        r.ack = ack;
        r.flags = flags;
        r.dlen = dlen;
        step_res.push_back(r);
    endfunction

    // Emit a segment header and advance the send sequence.
    function automatic void send_seg(int c, logic [7:0] flags, logic [15:0] dlen);
        logic [31:0] seq;
        seq = conn_sseq[c];
        add_res(KD_XMIT, STS_OK, c, seq, (flags & FL_ACK) ? conn_rack[c] : 32'd0, flags, dlen);
        if (flags & FL_SYN) seq = seq + 1;
        if (flags & FL_FIN) seq = seq + 1;
        conn_sseq[c] = seq + dlen;
    endfunction

    function automatic int grab_slot();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!conn_act[i]) begin
                conn_st[i] = CS_CLOSED;
                conn_ip[i] = '0;
                conn_rport[i] = '0;
                conn_lport[i] = '0;
                conn_sseq[i] = '0;
                conn_rack[i] = '0;
                conn_act[i] = 1;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int lookup(logic [31:0] ip, logic [15:0] rp, logic [15:0] lp);
        for (int i = 0; i < ENTRIES; i++)
            if (conn_act[i] && conn_ip[i] == ip && conn_rport[i] == rp && conn_lport[i] == lp)
                return i;
        return -1;
    endfunction

    function automatic bit listening(logic [15:0] lp);
        for (int i = 0; i < ENTRIES; i++)
            if (conn_act[i] && conn_st[i] == CS_LISTEN && conn_lport[i] == lp) return 1;
        return 0;
    endfunction

    function automatic void close_conn(int c);
        if (conn_st[c] == CS_ESTAB || conn_st[c] == CS_PEER_FIN) begin
            send_seg(c, FL_FIN | FL_ACK, 16'd0);
            conn_st[c] = (conn_st[c] == CS_ESTAB) ? CS_FW1 : CS_LAST_ACK;
        end
    endfunction

    // Received segment handling; returns the connection concerned.
    function automatic int rx_segment(cmd_t cmd);
        logic [15:0] hdr;
        logic [15:0] plen;
        int c;
        hdr = {10'd0, cmd.hwords, 2'd0};
        plen = (cmd.len > hdr) ? cmd.len - hdr : 16'd0;
        if (cmd.len < MIN_SEGMENT) begin
            add_res(KD_STATUS, STS_SHORT, -1, 0, 0, 0, 0);
            return -1;
        end
        c = lookup(cmd.ip, cmd.rport, cmd.lport);
        if (c < 0 && (cmd.flags & FL_SYN) && !(cmd.flags & FL_ACK)) begin
            if (!listening(cmd.lport)) begin
                add_res(KD_STATUS, STS_NO_LISTEN, -1, 0, 0, 0, 0);
                return -1;
            end
            c = grab_slot();
            if (c < 0) begin
                add_res(KD_STATUS, STS_FULL, -1, 0, 0, 0, 0);
                return -1;
            end
            conn_lport[c] = cmd.lport;
            conn_ip[c] = cmd.ip;
            conn_rport[c] = cmd.rport;
            conn_sseq[c] = SERVER_ISN;
            conn_rack[c] = cmd.seq + 1;
            conn_st[c] = CS_SYN_RCVD;
            send_seg(c, FL_SYN | FL_ACK, 16'd0);
            return c;
        end
        if (c < 0) begin
            add_res(KD_STATUS, STS_NO_CONN, -1, 0, 0, 0, 0);
            return -1;
        end
        case (conn_st[c])
            CS_SYN_SENT: begin
                if ((cmd.flags & FL_SYN) && (cmd.flags & FL_ACK)) begin
                    conn_rack[c] = cmd.seq + 1;
                    conn_st[c] = CS_ESTAB;
                    send_seg(c, FL_ACK, 16'd0);
                end
            end
            CS_SYN_RCVD: begin
                if (cmd.flags & FL_ACK) conn_st[c] = CS_ESTAB;
            end
            CS_ESTAB: begin
                if (plen > 0) begin
                    conn_rack[c] = cmd.seq + plen;
                    add_res(KD_DELIVER, STS_OK, c, 0, 0, 0, plen);
                end
                if (cmd.flags & FL_FIN) begin
                    conn_rack[c] = cmd.seq + 1;
                    conn_st[c] = CS_PEER_FIN;
                    send_seg(c, FL_ACK, 16'd0);
                    close_conn(c);
                end
            end
            CS_FW1, CS_FW2: begin
                if (conn_st[c] == CS_FW1 && (cmd.flags & FL_ACK)) conn_st[c] = CS_FW2;
                if (cmd.flags & FL_FIN) begin
                    conn_rack[c] = cmd.seq + 1;
                    send_seg(c, FL_ACK, 16'd0);
                    conn_st[c] = CS_LINGER;
                    conn_act[c] = 0;
                end
            end
            CS_LAST_ACK: begin
                if (cmd.flags & FL_ACK) begin
                    conn_st[c] = CS_CLOSED;
                    conn_act[c] = 0;
                end
            end
            default: begin
            end
        endcase
        if (step_res.size() == 0) add_res(KD_STATUS, STS_OK, c, 0, 0, 0, 0);
        return c;
    endfunction

    // Work out the results of one accepted command and queue them.
    function automatic void predict_step(cmd_t cmd);
        int c;
        c = -1;
        step_res.delete();
        if (cmd.op == OP_RECEIVE) begin
            c = rx_segment(cmd);
        end else if (cmd.op == OP_LISTEN || cmd.op == OP_CONNECT) begin
            c = grab_slot();
            if (c < 0) begin
                add_res(KD_STATUS, STS_FULL, -1, 0, 0, 0, 0);
            end else if (cmd.op == OP_LISTEN) begin
                conn_st[c] = CS_LISTEN;
                conn_lport[c] = cmd.lport;
                add_res(KD_STATUS, STS_OK, c, 0, 0, 0, 0);
            end else begin
                conn_lport[c] = cmd.lport;
                conn_ip[c] = cmd.ip;
                conn_rport[c] = cmd.rport;
                conn_sseq[c] = CLIENT_ISN;
                conn_st[c] = CS_SYN_SENT;
                send_seg(c, FL_SYN, 16'd0);
            end
        end else if (cmd.op == OP_SEND || cmd.op == OP_CLOSE) begin
            if (!conn_act[cmd.slot]) begin
                add_res(KD_STATUS, STS_NO_CONN, -1, 0, 0, 0, 0);
            end else begin
                c = int'(cmd.slot);
                if (cmd.op == OP_SEND) begin
                    if (conn_st[c] != CS_ESTAB) add_res(KD_STATUS, STS_NOT_ESTAB, c, 0, 0, 0, 0);
                    else send_seg(c, FL_ACK | FL_PSH, cmd.len);
                end else begin
                    close_conn(c);
                    if (step_res.size() == 0) add_res(KD_STATUS, STS_OK, c, 0, 0, 0, 0);
                end
            end
        end else begin
            add_res(KD_STATUS, STS_OK, -1, 0, 0, 0, 0);
        end
        foreach (step_res[k]) begin
            step_res[k].state = (c >= 0) ? conn_st[c] : CS_CLOSED;
            step_res[k].fin_mark = (k == step_res.size() - 1);
            owed_q.push_back(step_res[k]);
        end
    endfunction

    function automatic cmd_t mk_cmd(logic [2:0] op, logic [31:0] ip, logic [15:0] rp,
                                    logic [15:0] lp, logic [31:0] seq, logic [7:0] fl,
                                    logic [3:0] hw, logic [15:0] len, logic [2:0] sl);
        cmd_t c;
        c.op = op; c.ip = ip; c.rport = rp; c.lport = lp; c.seq = seq;
        c.flags = fl; c.hwords = hw; c.len = len; c.slot = sl;
        return c;
    endfunction

    // A segment from the peer of slot s.
    function automatic cmd_t peer_seg(int s, logic [7:0] fl, logic [15:0] len);
        return mk_cmd(OP_RECEIVE, conn_ip[s], conn_rport[s], conn_lport[s], $urandom,
                      fl, 4'd5, len, s[2:0]);
    endfunction

    // Random command, mostly one that moves a connection forward.
    function automatic cmd_t pick_cmd();
        int s;
        int lcount;
        logic [7:0] fl;
        cmd_t c;
        if ($urandom_range(0, 99) < 12) begin
            c = mk_cmd(3'($urandom_range(0, 7)), $urandom, 16'($urandom), 16'($urandom),
                       $urandom, 8'($urandom), 4'($urandom), 16'($urandom), 3'($urandom));
            if ($urandom_range(0, 1)) c.len = 16'($urandom_range(0, 40));
            return c;
        end
        s = $urandom_range(0, ENTRIES - 1);
        if (!conn_act[s]) begin
            lcount = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (conn_act[i] && conn_st[i] == CS_LISTEN) lcount++;
            if (lcount < 2 && $urandom_range(0, 4) == 0)
                return mk_cmd(OP_LISTEN, 0, 0, 16'($urandom), 0, 0, 0, 0, 0);
            return mk_cmd(OP_CONNECT, $urandom, 16'($urandom), 16'($urandom), 0, 0, 0, 0, 0);
        end
        case (conn_st[s])
            CS_LISTEN: begin
                c = mk_cmd(OP_RECEIVE, $urandom, 16'($urandom), conn_lport[s], $urandom,
                           FL_SYN | ($urandom_range(0, 1) ? FL_PSH : 8'h00), 4'd5,
                           16'($urandom_range(20, 80)), 0);
                return c;
            end
            CS_SYN_SENT: return peer_seg(s, FL_SYN | FL_ACK, 16'd20);
            CS_SYN_RCVD: return peer_seg(s, FL_ACK, 16'd20);
            CS_ESTAB: begin
                case ($urandom_range(0, 4))
                    0: return mk_cmd(OP_SEND, 0, 0, 0, 0, 0, 0, 16'($urandom), s[2:0]);
                    1: return peer_seg(s, FL_ACK | FL_PSH, 16'($urandom_range(20, 1500)));
                    2: return peer_seg(s, FL_ACK | FL_FIN, 16'($urandom_range(20, 600)));
                    3: return mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, s[2:0]);
                    default: return peer_seg(s, FL_FIN, 16'd20);
                endcase
            end
            CS_FW1, CS_FW2: begin
                case ($urandom_range(0, 2))
                    0: fl = FL_ACK;
                    1: fl = FL_FIN;
                    default: fl = FL_FIN | FL_ACK;
                endcase
                return peer_seg(s, fl, 16'd20);
            end
            CS_PEER_FIN: return mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, s[2:0]);
            default: return peer_seg(s, FL_ACK, 16'd20);
        endcase
    endfunction

    // Offer one request in bursts with random gaps, then wait for acceptance.
    task automatic drive(cmd_t cmd, bit chk, logic [2:0] sts);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, cmd.slot, cmd.len, cmd.hwords, cmd.flags, cmd.seq,
                         cmd.lport, cmd.rport, cmd.ip};
        s_axis_tuser <= cmd.op;
        typed_chk = chk;
        typed_sts = sts;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
    endtask

    function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
        end
    endfunction

    // Predict on accepted requests, check accepted results, and watch for a hang.
    always @(posedge i_clk) begin
        cmd_t c;
        res_t e;
        res_t a;
        if (i_rst_n) begin
            idle_cycles++;
            if (s_axis_tvalid && s_axis_tready) begin
                idle_cycles = 0;
                {c.slot, c.len, c.hwords, c.flags, c.seq, c.lport, c.rport, c.ip} =
                    s_axis_tdata[126:0];
                c.op = s_axis_tuser;
                predict_step(c);
                if (typed_chk && step_res[0].status !== typed_sts) begin
                    errors++;
                    $display("%0t: typed status mismatch, expected %0d, actual %0d",
                             $time, typed_sts, step_res[0].status);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                idle_cycles = 0;
                {a.state, a.dlen, a.flags, a.ack, a.seq, a.lport, a.rport, a.ip,
                 a.slot, a.status} = m_axis_tdata[161:0];
                a.kind = m_axis_tuser;
                a.fin_mark = m_axis_tlast;
                if (owed_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                             $time, a.kind, a.status);
                end else begin
                    e = owed_q.pop_front();
                    cmp_field("kind", e.kind, a.kind);
                    cmp_field("status", e.status, a.status);
                    cmp_field("conn_slot", e.slot, a.slot);
                    cmp_field("peer_ip", e.ip, a.ip);
                    cmp_field("peer_port", e.rport, a.rport);
                    cmp_field("own_port", e.lport, a.lport);
                    cmp_field("tx_seq", e.seq, a.seq);
                    cmp_field("tx_ack", e.ack, a.ack);
                    cmp_field("tx_flags", e.flags, a.flags);
                    cmp_field("data_len", e.dlen, a.dlen);
                    cmp_field("conn_state", e.state, a.state);
                    cmp_field("tlast", e.fin_mark, a.fin_mark);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** tcp_connection_state_engine_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: changing stall pattern, plus one long hold on request.
    initial begin
        int hold;
        int mode;
        hold = 0;
        mode = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                hold = LONG_HOLD;
            end
            if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin
        row_t rows[$];
        row_t r;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_RECEIVE;
        for (int i = 0; i < ENTRIES; i++) conn_act[i] = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Errors and ignored commands on an empty table.
        rows.push_back('{mk_cmd(OP_RECEIVE, 0, 0, 0, 0, FL_SYN, 5, 19, 0), 1, STS_SHORT});
        rows.push_back('{mk_cmd(OP_RECEIVE, 1, 2, 16'hFFFF, 0, FL_SYN, 5, 20, 0), 1,
                         STS_NO_LISTEN});
        rows.push_back('{mk_cmd(OP_RECEIVE, 1, 2, 3, 0, FL_ACK, 5, 20, 0), 1, STS_NO_CONN});
        rows.push_back('{mk_cmd(OP_SEND, 0, 0, 0, 0, 0, 0, 100, 0), 1, STS_NO_CONN});
        rows.push_back('{mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 7), 1, STS_NO_CONN});
        rows.push_back('{mk_cmd(3'd7, '1, '1, '1, '1, '1, '1, '1, '1), 1, STS_OK});
        rows.push_back('{mk_cmd(3'd5, 0, 0, 0, 0, 0, 0, 0, 0), 1, STS_OK});
        // Passive open, data with FIN, immediate close after the peer FIN, final ACK.
        rows.push_back('{mk_cmd(OP_LISTEN, 0, 0, 16'hFFFF, 0, 0, 0, 0, 0), 1, STS_OK});
        rows.push_back('{mk_cmd(OP_RECEIVE, '1, 0, 16'hFFFF, '1, FL_SYN, 5, 20, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, '1, 0, 16'hFFFF, 0, FL_ACK, 5, 20, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, '1, 0, 16'hFFFF, '1, FL_FIN | FL_ACK | FL_PSH,
                                5, 16'hFFFF, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, '1, 0, 16'hFFFF, 0, FL_ACK, 5, 20, 0), 0, 0});
        // Active open, send, header longer than segment, active close to release.
        rows.push_back('{mk_cmd(OP_CONNECT, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, 0, 16'hFFFF, 0, 0, FL_SYN | FL_ACK, 5, 20, 0),
                         0, 0});
        rows.push_back('{mk_cmd(OP_SEND, 0, 0, 0, 0, 0, 0, 16'hFFFF, 1), 0, 0});
        rows.push_back('{mk_cmd(OP_SEND, 0, 0, 0, 0, 0, 0, 5, 0), 1, STS_NOT_ESTAB});
        rows.push_back('{mk_cmd(OP_RECEIVE, 0, 16'hFFFF, 0, 7, 8'h00, 15, 20, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 1), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, 0, 16'hFFFF, 0, 9, FL_ACK, 5, 20, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_RECEIVE, 0, 16'hFFFF, 0, 9, FL_FIN, 5, 20, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0, 0, 0), 1, STS_OK});
        // Fill the table, then hit it full from both sides.
        for (int i = 1; i < ENTRIES; i++)
            rows.push_back('{mk_cmd(OP_CONNECT, 32'(32'h0A00_0000 + i), 80, 16'(1000 + i),
                                    0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk_cmd(OP_CONNECT, 5, 5, 5, 0, 0, 0, 0, 0), 1, STS_FULL});
        rows.push_back('{mk_cmd(OP_RECEIVE, 6, 6, 16'hFFFF, 0, FL_SYN, 5, 20, 0), 1,
                         STS_FULL});

        foreach (rows[i]) drive(rows[i].cmd, rows[i].chk, rows[i].sts);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 150) begin
                // Let everything drain before going on.
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                burst_left = 0;
                while (owed_q.size() != 0) @(negedge i_clk);
            end
            if (n == 300) hold_req = 1;
            drive(pick_cmd(), 0, STS_OK);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (owed_q.size() != 0) @(negedge i_clk);
        repeat (ENTRIES + 20) @(negedge i_clk);
        if (errors == 0) begin
            $display("** tcp_connection_state_engine_unit: PASSED **");
        end else begin
            $display("** tcp_connection_state_engine_unit: FAILED **");
        end
        $finish;
    end

endmodule
